@@ rtl/boae_pkg.sv @@
// ---------------------------------------------------------------------------
// boae_pkg: shared types and constants of the bounded ordered array engine
// sizes, operation and status codes, controller states, limit helpers
// ---------------------------------------------------------------------------
package boae_pkg;

  localparam int DEPTH       = 64;
  localparam int ENTRY_WIDTH = 32;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int CFG_W       = 7;
  localparam int CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENTRIES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALLOC_STEP  = 1'b1;

  localparam logic [CFG_W-1:0] RESET_MAX_ENTRIES = 7'd64;
  localparam logic [CFG_W-1:0] RESET_ALLOC_STEP  = 7'd8;

  typedef enum logic [2:0] {
    OP_APPEND     = 3'd0,
    OP_POP_FIRST  = 3'd1,
    OP_POP_LAST   = 3'd2,
    OP_DEL_MATCH  = 3'd3,
    OP_DEL_INDEX  = 3'd4,
    OP_READ_INDEX = 3'd5,
    OP_LOCK       = 3'd6,
    OP_UNLOCK     = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_LIMIT  = 3'd1,
    ST_LOCKED = 3'd2,
    ST_NONE   = 3'd3,
    ST_SAME   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_t;

  // zero reads as one, oversize reads as the depth
  function automatic logic [CNT_W-1:0] eff_unit(input logic [CFG_W-1:0] u);
    logic [CNT_W-1:0] r;
    if (u == '0) begin
      r = CNT_W'(1);
    end else if (int'(u) > DEPTH) begin
      r = CNT_W'(DEPTH);
    end else begin
      r = CNT_W'(u);
    end
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] eff_limit(input logic [CFG_W-1:0] m);
    logic [CNT_W-1:0] r;
    if (int'(m) > DEPTH) begin
      r = CNT_W'(DEPTH);
    end else begin
      r = CNT_W'(m);
    end
    return r;
  endfunction

endpackage

@@ rtl/bounded_ordered_array_engine.sv @@
// ---------------------------------------------------------------------------
// bounded_ordered_array_engine: dense ordered array with compaction
// entries live in one single-port-read, single-port-write synchronous ram;
// a small controller walks it for match search and compaction
// ---------------------------------------------------------------------------
// flow: a request is taken while idle and checked in exec; append, lock,
//   unlock and refused requests go from there to done, and the next request
//   is taken once the result is loaded; pop first, pop last and read index
//   read the ram, then a pop shifts the entries above the removed one down;
//   delete index shifts at once; delete match scans up to the first match or
//   the last entry, then shifts; the ram walk moves one entry per cycle
// reset: empty, 8 slots allocated, unlocked, limit 64, unit 8; ram not cleared
module bounded_ordered_array_engine (
  input  logic                                clk,
  input  logic                                rst,
  // request channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [2:0]                          kind,
  input  logic [boae_pkg::ENTRY_WIDTH-1:0]    entry_value,
  input  logic [boae_pkg::ADDR_W-1:0]         entry_index,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [2:0]                          status,
  output logic [boae_pkg::ENTRY_WIDTH-1:0]    entry_value_out,
  output logic [boae_pkg::CNT_W-1:0]          entry_count,
  output logic [boae_pkg::CNT_W-1:0]          allocated_count,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [boae_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [boae_pkg::CFG_W-1:0]          cfg_data
);

  localparam int AW = boae_pkg::ADDR_W;
  localparam int CW = boae_pkg::CNT_W;
  localparam int EW = boae_pkg::ENTRY_WIDTH;

  // entry ram
  logic [EW-1:0] store [boae_pkg::DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [EW-1:0] rdata;

  // configuration and array state
  logic [boae_pkg::CFG_W-1:0] max_entries;
  logic [boae_pkg::CFG_W-1:0] alloc_step;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] alloc, alloc_next;
  logic          locked, locked_next;

  // request being worked on
  boae_pkg::state_t  state, state_next;
  boae_pkg::op_t     op;
  logic [EW-1:0]     val;
  logic [AW-1:0]     idx;
  logic [CW-1:0]     ptr, ptr_next;
  boae_pkg::status_t res_status, res_status_next;
  logic [EW-1:0]     res_vout, res_vout_next;

  // derived values
  logic [CW-1:0]   unit;
  logic [CW-1:0]   limit;
  logic            is_full;
  logic [CW-1:0]   count_m1;
  logic [CW:0]     grow_sum;
  logic [CW-1:0]   alloc_grown;
  logic [CW+1:0]   shrink_sum;
  logic [CW-1:0]   alloc_shrunk;
  logic            refuse;
  boae_pkg::status_t refuse_code;
  logic [CW-1:0]   rm_pos;
  logic [CW:0]     rm_pos_p1;
  logic            rm_more;
  logic [CW:0]     ptr_p1;
  logic [CW:0]     ptr_p2;
  logic            scan_hit;
  logic            scan_more;
  logic            shift_more;
  logic            out_free;

  assign unit     = boae_pkg::eff_unit(alloc_step);
  assign limit    = boae_pkg::eff_limit(max_entries);
  assign is_full  = alloc <= count;
  assign count_m1 = count - CW'(1);

  // growth saturates at the depth
  assign grow_sum    = {1'b0, alloc} + {1'b0, unit};
  assign alloc_grown = (grow_sum > (CW+1)'(boae_pkg::DEPTH)) ? CW'(boae_pkg::DEPTH)
                                                             : grow_sum[CW-1:0];

  // shrink once two units sit unused after the removal; removals only run unlocked
  assign shrink_sum   = {2'b00, count_m1} + {1'b0, unit, 1'b0};
  assign alloc_shrunk = (shrink_sum <= {2'b00, alloc}) ? (alloc - unit) : alloc;

  // refusal checks, lock first then existence; for append the limit comes before the lock
  always_comb begin
    refuse      = 1'b0;
    refuse_code = boae_pkg::ST_OK;
    case (op)
      boae_pkg::OP_APPEND: begin
        if (count >= limit) begin
          refuse      = 1'b1;
          refuse_code = boae_pkg::ST_LIMIT;
        end else if (is_full && locked) begin
          refuse      = 1'b1;
          refuse_code = boae_pkg::ST_LOCKED;
        end
      end
      boae_pkg::OP_POP_FIRST, boae_pkg::OP_POP_LAST, boae_pkg::OP_DEL_MATCH: begin
        if (locked) begin
          refuse      = 1'b1;
          refuse_code = boae_pkg::ST_LOCKED;
        end else if (count == '0) begin
          refuse      = 1'b1;
          refuse_code = boae_pkg::ST_NONE;
        end
      end
      boae_pkg::OP_DEL_INDEX: begin
        if (locked) begin
          refuse      = 1'b1;
          refuse_code = boae_pkg::ST_LOCKED;
        end else if (CW'(idx) >= count) begin
          refuse      = 1'b1;
          refuse_code = boae_pkg::ST_NONE;
        end
      end
      boae_pkg::OP_READ_INDEX: begin
        if (CW'(idx) >= count) begin
          refuse      = 1'b1;
          refuse_code = boae_pkg::ST_NONE;
        end
      end
      boae_pkg::OP_LOCK: begin
        if (locked) begin
          refuse      = 1'b1;
          refuse_code = boae_pkg::ST_SAME;
        end
      end
      default: begin
        if (!locked) begin
          refuse      = 1'b1;
          refuse_code = boae_pkg::ST_SAME;
        end
      end
    endcase
  end

  // position of the entry being removed, by the state that starts compaction
  always_comb begin
    case (state)
      boae_pkg::S_EXEC: rm_pos = CW'(idx);
      boae_pkg::S_READ: rm_pos = (op == boae_pkg::OP_POP_FIRST) ? '0 : count_m1;
      default:          rm_pos = ptr;
    endcase
  end

  assign rm_pos_p1  = {1'b0, rm_pos} + (CW+1)'(1);
  assign rm_more    = rm_pos_p1 < {1'b0, count};
  assign ptr_p1     = {1'b0, ptr} + (CW+1)'(1);
  assign ptr_p2     = {1'b0, ptr} + (CW+1)'(2);
  assign scan_hit   = rdata == val;
  assign scan_more  = ptr_p1 < {1'b0, count};
  assign shift_more = ptr_p2 < {1'b0, count};
  assign out_free   = !out_valid || !out_stall;

  // no request taken during reset, on a configuration write or while a request is in work
  assign in_stall = rst || cfg_we || state != boae_pkg::S_IDLE;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      boae_pkg::S_IDLE: begin
        if (in_valid) state_next = boae_pkg::S_EXEC;
      end
      boae_pkg::S_EXEC: begin
        if (refuse) begin
          state_next = boae_pkg::S_DONE;
        end else begin
          case (op)
            boae_pkg::OP_POP_FIRST, boae_pkg::OP_POP_LAST,
            boae_pkg::OP_READ_INDEX: state_next = boae_pkg::S_READ;
            boae_pkg::OP_DEL_MATCH:  state_next = boae_pkg::S_SCAN;
            boae_pkg::OP_DEL_INDEX:
              state_next = rm_more ? boae_pkg::S_SHIFT : boae_pkg::S_DONE;
            default:                 state_next = boae_pkg::S_DONE;
          endcase
        end
      end
      boae_pkg::S_READ: begin
        if (op != boae_pkg::OP_READ_INDEX && rm_more) state_next = boae_pkg::S_SHIFT;
        else state_next = boae_pkg::S_DONE;
      end
      boae_pkg::S_SCAN: begin
        if (scan_hit) state_next = rm_more ? boae_pkg::S_SHIFT : boae_pkg::S_DONE;
        else if (!scan_more) state_next = boae_pkg::S_DONE;
      end
      boae_pkg::S_SHIFT: begin
        if (!shift_more) state_next = boae_pkg::S_DONE;
      end
      boae_pkg::S_DONE: begin
        if (out_free) state_next = boae_pkg::S_IDLE;
      end
      default: state_next = boae_pkg::S_IDLE;
    endcase
  end

  // ram accesses and state updates
  always_comb begin
    mem_we          = 1'b0;
    mem_waddr       = count[AW-1:0];
    mem_wdata       = val;
    mem_re          = 1'b0;
    mem_raddr       = '0;
    count_next      = count;
    alloc_next      = alloc;
    locked_next     = locked;
    ptr_next        = ptr;
    res_status_next = res_status;
    res_vout_next   = res_vout;
    case (state)
      boae_pkg::S_EXEC: begin
        res_vout_next = '0;
        if (refuse) begin
          res_status_next = refuse_code;
        end else begin
          res_status_next = boae_pkg::ST_OK;
          case (op)
            boae_pkg::OP_APPEND: begin
              mem_we     = 1'b1;
              count_next = count + CW'(1);
              if (is_full) alloc_next = alloc_grown;
            end
            boae_pkg::OP_POP_FIRST: begin
              mem_re = 1'b1;
            end
            boae_pkg::OP_POP_LAST: begin
              mem_re    = 1'b1;
              mem_raddr = count_m1[AW-1:0];
            end
            boae_pkg::OP_READ_INDEX: begin
              mem_re    = 1'b1;
              mem_raddr = idx;
            end
            boae_pkg::OP_DEL_MATCH: begin
              mem_re   = 1'b1;
              ptr_next = '0;
            end
            boae_pkg::OP_DEL_INDEX: begin
              ptr_next = rm_pos;
              if (rm_more) begin
                mem_re    = 1'b1;
                mem_raddr = rm_pos_p1[AW-1:0];
              end else begin
                count_next = count_m1;
                alloc_next = alloc_shrunk;
              end
            end
            boae_pkg::OP_LOCK: locked_next = 1'b1;
            default:           locked_next = 1'b0;
          endcase
        end
      end
      boae_pkg::S_READ: begin
        res_vout_next = rdata;
        if (op != boae_pkg::OP_READ_INDEX) begin
          ptr_next = rm_pos;
          if (rm_more) begin
            mem_re    = 1'b1;
            mem_raddr = rm_pos_p1[AW-1:0];
          end else begin
            count_next = count_m1;
            alloc_next = alloc_shrunk;
          end
        end
      end
      boae_pkg::S_SCAN: begin
        if (scan_hit) begin
          if (rm_more) begin
            mem_re    = 1'b1;
            mem_raddr = rm_pos_p1[AW-1:0];
          end else begin
            count_next = count_m1;
            alloc_next = alloc_shrunk;
          end
        end else if (scan_more) begin
          mem_re    = 1'b1;
          mem_raddr = ptr_p1[AW-1:0];
          ptr_next  = ptr_p1[CW-1:0];
        end else begin
          res_status_next = boae_pkg::ST_NONE;
        end
      end
      boae_pkg::S_SHIFT: begin
        // move the entry above down one place, fetch the next one
        mem_we    = 1'b1;
        mem_waddr = ptr[AW-1:0];
        mem_wdata = rdata;
        if (shift_more) begin
          mem_re    = 1'b1;
          mem_raddr = ptr_p2[AW-1:0];
          ptr_next  = ptr_p1[CW-1:0];
        end else begin
          count_next = count_m1;
          alloc_next = alloc_shrunk;
        end
      end
      default: begin
      end
    endcase
  end

  // entry ram, read data registered
  always_ff @(posedge clk) begin
    if (mem_we) store[mem_waddr] <= mem_wdata;
    if (mem_re) rdata <= store[mem_raddr];
  end

  // request capture and work registers
  always_ff @(posedge clk) begin
    if (state == boae_pkg::S_IDLE && in_valid) begin
      op  <= boae_pkg::op_t'(kind);
      val <= entry_value;
      idx <= entry_index;
    end
    ptr        <= ptr_next;
    res_status <= res_status_next;
    res_vout   <= res_vout_next;
  end

  // control state; configuration writes are for the user to make only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= boae_pkg::S_IDLE;
      max_entries <= boae_pkg::RESET_MAX_ENTRIES;
      alloc_step  <= boae_pkg::RESET_ALLOC_STEP;
      count       <= '0;
      alloc       <= boae_pkg::eff_unit(boae_pkg::RESET_ALLOC_STEP);
      locked      <= 1'b0;
    end else if (cfg_we) begin
      // any write empties the array and sets one unit of allocation
      count <= '0;
      if (cfg_index == boae_pkg::CFG_MAX_ENTRIES) begin
        max_entries <= cfg_data;
        alloc       <= unit;
      end else begin
        alloc_step  <= cfg_data;
        alloc       <= boae_pkg::eff_unit(cfg_data);
      end
    end else begin
      state  <= state_next;
      count  <= count_next;
      alloc  <= alloc_next;
      locked <= locked_next;
    end
  end

  // result register, taken while the next request may already be accepted
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == boae_pkg::S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == boae_pkg::S_DONE && out_free) begin
      status          <= res_status;
      entry_value_out <= res_vout;
      entry_count     <= count;
      allocated_count <= alloc;
    end
  end

endmodule

@@ verif/bounded_ordered_array_engine_tb.sv @@
// ---------------------------------------------------------------------------
// bounded_ordered_array_engine_tb: self-checking bench of the array engine
// drives array requests through the valid/stall channel, predicts each
// result with a shadow copy of the array, and compares every result field
// ---------------------------------------------------------------------------
module bounded_ordered_array_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = boae_pkg::DEPTH;
  localparam int ENTRY_WIDTH = boae_pkg::ENTRY_WIDTH;
  localparam int ADDR_W      = boae_pkg::ADDR_W;
  localparam int CNT_W       = boae_pkg::CNT_W;
  localparam int CFG_W       = boae_pkg::CFG_W;
  localparam int CFG_IDX_W   = boae_pkg::CFG_IDX_W;

  // cycles without any handshake before the run is declared hung
  localparam int IDLE_LIMIT      = 3000;
  // long receiver hold-off so the engine backs up into its request side
  localparam int HOLD_OFF_CYCLES = 300;
  // quiet time at the end: worst walk through the ram plus margin
  localparam int DRAIN_CYCLES    = 2 * DEPTH + 16;
  localparam int NUM_PHASES      = 9;

  typedef struct packed {
    boae_pkg::op_t          op;
    logic [ENTRY_WIDTH-1:0] value;
    logic [ADDR_W-1:0]      index;
  } array_req_t;

  typedef struct packed {
    boae_pkg::status_t      status;
    logic [ENTRY_WIDTH-1:0] value;
    logic [CNT_W-1:0]       count;
    logic [CNT_W-1:0]       slots;
  } array_resp_t;

  logic                   clk         = 1'b0;
  logic                   rst         = 1'b1;
  logic                   in_valid    = 1'b0;
  logic                   in_stall;
  logic [2:0]             kind        = '0;
  logic [ENTRY_WIDTH-1:0] entry_value = '0;
  logic [ADDR_W-1:0]      entry_index = '0;
  logic                   out_valid;
  logic                   out_stall   = 1'b0;
  logic [2:0]             status;
  logic [ENTRY_WIDTH-1:0] entry_value_out;
  logic [CNT_W-1:0]       entry_count;
  logic [CNT_W-1:0]       allocated_count;
  logic                   cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index   = '0;
  logic [CFG_W-1:0]       cfg_data    = '0;

  bounded_ordered_array_engine i_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .kind            (kind),
    .entry_value     (entry_value),
    .entry_index     (entry_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .entry_value_out (entry_value_out),
    .entry_count     (entry_count),
    .allocated_count (allocated_count),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow array state, starts at the engine's reset values
  logic [ENTRY_WIDTH-1:0] shadow_entries [DEPTH];
  int                     shadow_count  = 0;
  int                     shadow_slots  = 8;
  bit                     shadow_locked = 1'b0;
  logic [CFG_W-1:0]       shadow_max    = boae_pkg::RESET_MAX_ENTRIES;
  logic [CFG_W-1:0]       shadow_unit   = boae_pkg::RESET_ALLOC_STEP;

  array_req_t  pending_requests [$];
  array_resp_t expected_results [$];

  bit  offering   = 1'b0;   // a request is on the bus, not yet taken
  bit  idle_en    = 1'b1;   // random gaps on both sides when set
  int  mismatches = 0;
  int  hold_ask   = 0;      // bumped by the stimulus to ask for a hold-off
  int  hold_seen  = 0;
  logic [ENTRY_WIDTH-1:0] value_pool [8];

  // allocation step as the engine applies it: zero means one, capped at depth
  function automatic int unit_now();
    if (shadow_unit == '0) return 1;
    if (int'(shadow_unit) > DEPTH) return DEPTH;
    return int'(shadow_unit);
  endfunction

  // drop one entry, close the hole, give back a unit past the hysteresis
  task automatic remove_entry(input int pos);
    int u;
    u = unit_now();
    for (int i = pos; i + 1 < shadow_count; i++) shadow_entries[i] = shadow_entries[i + 1];
    shadow_count--;
    if (shadow_count + 2 * u <= shadow_slots && !shadow_locked) shadow_slots -= u;
  endtask

  // apply one request to the shadow array and form the result it gives
  task automatic predict_array_op(input array_req_t rq, output array_resp_t rs);
    boae_pkg::status_t      st;
    logic [ENTRY_WIDTH-1:0] vout;
    int                     limit;
    int                     pos;
    int                     idx;
    st    = boae_pkg::ST_OK;
    vout  = '0;
    idx   = int'(rq.index);
    limit = (int'(shadow_max) > DEPTH) ? DEPTH : int'(shadow_max);
    case (rq.op)
      boae_pkg::OP_APPEND: begin
        // limit wins over the lock
        if (shadow_count >= limit) begin
          st = boae_pkg::ST_LIMIT;
        end else if (shadow_slots <= shadow_count && shadow_locked) begin
          st = boae_pkg::ST_LOCKED;
        end else begin
          if (shadow_slots <= shadow_count) begin
            shadow_slots += unit_now();
            if (shadow_slots > DEPTH) shadow_slots = DEPTH;
          end
          shadow_entries[shadow_count] = rq.value;
          shadow_count++;
        end
      end
      boae_pkg::OP_POP_FIRST, boae_pkg::OP_POP_LAST: begin
        if (shadow_locked) begin
          st = boae_pkg::ST_LOCKED;
        end else if (shadow_count == 0) begin
          st = boae_pkg::ST_NONE;
        end else begin
          pos  = (rq.op == boae_pkg::OP_POP_FIRST) ? 0 : shadow_count - 1;
          vout = shadow_entries[pos];
          remove_entry(pos);
        end
      end
      boae_pkg::OP_DEL_MATCH: begin
        if (shadow_locked) begin
          st = boae_pkg::ST_LOCKED;
        end else begin
          pos = -1;
          for (int i = 0; i < shadow_count; i++) begin
            if (pos < 0 && shadow_entries[i] == rq.value) pos = i;
          end
          if (pos < 0) st = boae_pkg::ST_NONE;
          else remove_entry(pos);
        end
      end
      boae_pkg::OP_DEL_INDEX: begin
        if (shadow_locked) st = boae_pkg::ST_LOCKED;
        else if (idx >= shadow_count) st = boae_pkg::ST_NONE;
        else remove_entry(idx);
      end
      boae_pkg::OP_READ_INDEX: begin
        if (idx >= shadow_count) st = boae_pkg::ST_NONE;
        else vout = shadow_entries[idx];
      end
      boae_pkg::OP_LOCK: begin
        if (shadow_locked) st = boae_pkg::ST_SAME;
        shadow_locked = 1'b1;
      end
      default: begin
        if (!shadow_locked) st = boae_pkg::ST_SAME;
        shadow_locked = 1'b0;
      end
    endcase
    rs.status = st;
    rs.value  = vout;
    rs.count  = CNT_W'(shadow_count);
    rs.slots  = CNT_W'(shadow_slots);
  endtask

  // mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // ------------------------------------------------------------------------
  // request driver: samples the handshake at the rising edge, predicts the
  // taken request, then presents the next one at the falling edge
  // ------------------------------------------------------------------------
  always begin : request_driver
    array_req_t  cur;
    array_resp_t want;
    int          send_gap;
    @(posedge clk);
    if (in_valid && !in_stall) begin
      predict_array_op(cur, want);
      expected_results.push_back(want);
      offering = 1'b0;
    end
    @(negedge clk);
    // a request on the bus stays put until taken
    if (!offering) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_requests.size() != 0) begin
        cur          = pending_requests.pop_front();
        kind        <= cur.op;
        entry_value <= cur.value;
        entry_index <= cur.index;
        in_valid    <= 1'b1;
        offering     = 1'b1;
        send_gap     = idle_en ? pick_gap() : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------------------
  // result monitor: checks taken results at the rising edge against the
  // oldest prediction, then picks the stall for the next cycle
  // ------------------------------------------------------------------------
  always begin : result_monitor
    array_resp_t want;
    int          hold_left;
    int          stall_left;
    @(posedge clk);
    if (out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: status %0d value %h count %0d slots %0d",
                   status, entry_value_out, entry_count, allocated_count);
        end
      end else begin
        want = expected_results.pop_front();
        if (status !== want.status || entry_value_out !== want.value ||
            entry_count !== want.count || allocated_count !== want.slots) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result mismatch: expected status %0d value %h count %0d slots %0d",
                     want.status, want.value, want.count, want.slots);
            $display("                 got      status %0d value %h count %0d slots %0d",
                     status, entry_value_out, entry_count, allocated_count);
          end
        end
      end
    end
    @(negedge clk);
    if (hold_ask != hold_seen) begin
      hold_seen = hold_ask;
      hold_left = HOLD_OFF_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      stall_left = idle_en ? pick_gap() : 0;
    end
  end

  // hang detector: any handshake restarts the count
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("TEST FAILED");
    $finish;
  end

  task automatic push_request(input boae_pkg::op_t op,
                              input logic [ENTRY_WIDTH-1:0] value,
                              input logic [ADDR_W-1:0] index);
    array_req_t rq;
    rq.op    = op;
    rq.value = value;
    rq.index = index;
    pending_requests.push_back(rq);
  endtask

  // sender stops until every request has come back, then a short pause
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_requests.size() != 0 || offering || expected_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // both registers written back to back; each write empties the array
  task automatic write_config(input logic [CFG_W-1:0] limit_val,
                              input logic [CFG_W-1:0] unit_val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= boae_pkg::CFG_MAX_ENTRIES;
    cfg_data  <= limit_val;
    @(negedge clk);
    cfg_index <= boae_pkg::CFG_ALLOC_STEP;
    cfg_data  <= unit_val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    shadow_max   = limit_val;
    shadow_unit  = unit_val;
    shadow_count = 0;
    shadow_slots = unit_now();
  endtask

  // random request: appends at the given share, values mostly from a small
  // pool so that delete by match finds entries and duplicates
  task automatic queue_random_requests(input int n, input int append_pct);
    boae_pkg::op_t          op;
    logic [ENTRY_WIDTH-1:0] value;
    logic [ADDR_W-1:0]      index;
    int                     r;
    value_pool[0] = '0;
    value_pool[1] = '1;
    for (int i = 2; i < 8; i++) value_pool[i] = ENTRY_WIDTH'($urandom());
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < append_pct) begin
        op = boae_pkg::OP_APPEND;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 15) op = boae_pkg::OP_POP_FIRST;
        else if (r < 30) op = boae_pkg::OP_POP_LAST;
        else if (r < 50) op = boae_pkg::OP_DEL_MATCH;
        else if (r < 65) op = boae_pkg::OP_DEL_INDEX;
        else if (r < 85) op = boae_pkg::OP_READ_INDEX;
        else if (r < 90) op = boae_pkg::OP_LOCK;
        else op = boae_pkg::OP_UNLOCK;
      end
      if ($urandom_range(0, 9) == 0) value = ENTRY_WIDTH'($urandom());
      else value = value_pool[$urandom_range(0, 7)];
      if ($urandom_range(0, 2) == 0) index = ADDR_W'($urandom_range(0, DEPTH - 1));
      else index = ADDR_W'($urandom_range(0, 7));
      push_request(op, value, index);
    end
  endtask

  // ------------------------------------------------------------------------
  // stimulus: directed sequence on a tiny array, then random phases over a
  // range of limit and unit settings, including zero and oversize values
  // ------------------------------------------------------------------------
  initial begin : stimulus
    int phase_limit  [NUM_PHASES];
    int phase_unit   [NUM_PHASES];
    int phase_items  [NUM_PHASES];
    int phase_append [NUM_PHASES];
    bit phase_idle   [NUM_PHASES];

    phase_limit  = '{64, 0, 127, 64, 100, 64, 3, 40, 64};
    phase_unit   = '{8, 1, 0, 64, 100, 5, 1, 3, 8};
    phase_items  = '{70, 30, 70, 50, 50, 90, 40, 60, 40};
    phase_append = '{60, 50, 65, 55, 60, 75, 50, 50, 50};
    phase_idle   = '{1, 1, 0, 1, 1, 1, 0, 1, 1};

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // limit 5, unit 2: growth, the limit and the shrink are all close by
    write_config(7'd5, 7'd2);
    // every removal and read on an empty array
    push_request(boae_pkg::OP_POP_FIRST, '0, '0);
    push_request(boae_pkg::OP_POP_LAST, '0, '0);
    push_request(boae_pkg::OP_DEL_MATCH, '0, '0);
    push_request(boae_pkg::OP_DEL_INDEX, '0, '0);
    push_request(boae_pkg::OP_READ_INDEX, '0, 6'd63);
    // unlock while already unlocked
    push_request(boae_pkg::OP_UNLOCK, '0, '0);
    push_request(boae_pkg::OP_APPEND, 32'h0000_0000, '0);
    push_request(boae_pkg::OP_APPEND, 32'hffff_ffff, '0);
    push_request(boae_pkg::OP_LOCK, '0, '0);
    push_request(boae_pkg::OP_LOCK, '0, '0);
    // locked: append needing growth, pops and deletes are refused
    push_request(boae_pkg::OP_APPEND, 32'h0000_0001, '0);
    push_request(boae_pkg::OP_POP_FIRST, '0, '0);
    push_request(boae_pkg::OP_POP_LAST, '0, '0);
    push_request(boae_pkg::OP_DEL_MATCH, 32'h0000_0000, '0);
    push_request(boae_pkg::OP_DEL_INDEX, '0, '0);
    // read stays allowed under the lock
    push_request(boae_pkg::OP_READ_INDEX, '0, 6'd1);
    push_request(boae_pkg::OP_UNLOCK, '0, '0);
    push_request(boae_pkg::OP_APPEND, 32'h1234_5678, '0);
    push_request(boae_pkg::OP_APPEND, 32'h8765_4321, '0);
    push_request(boae_pkg::OP_APPEND, 32'hdead_beef, '0);
    // array at its limit
    push_request(boae_pkg::OP_APPEND, 32'h0000_0000, '0);
    push_request(boae_pkg::OP_DEL_MATCH, 32'hffff_ffff, '0);
    push_request(boae_pkg::OP_DEL_INDEX, '0, 6'd63);
    push_request(boae_pkg::OP_DEL_INDEX, '0, 6'd1);
    // pop first releases a unit here
    push_request(boae_pkg::OP_POP_FIRST, '0, '0);
    push_request(boae_pkg::OP_POP_LAST, '0, '0);
    push_request(boae_pkg::OP_READ_INDEX, '0, 6'd0);
    wait_idle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_config(CFG_W'(phase_limit[p]), CFG_W'(phase_unit[p]));
      idle_en = phase_idle[p];
      // first phase: receiver holds off while requests keep coming
      if (p == 0) hold_ask++;
      queue_random_requests(phase_items[p], phase_append[p]);
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
